// ===== design/dq_pkg.sv =====
// shared constants, codes and controller command type for the double-ended queue
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    localparam int IN_W  = ((CMD_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W = ((STAT_W + 2 * DATA_W + 1 + CNT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic fetch;
        logic load;
    } dq_ctrl_t;

endpackage

// ===== design/dq_datapath.sv =====
// ring store, head and count registers, and the result register
module dq_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dq_pkg::dq_ctrl_t          ctrl,
    input  logic [dq_pkg::IN_W-1:0]   in_data,
    output logic [dq_pkg::OUT_W-1:0]  out_data
);

    logic [dq_pkg::CMD_W-1:0]  cmd_reg;
    logic [dq_pkg::DATA_W-1:0] word_reg;
    logic [dq_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [dq_pkg::CNT_W-1:0]  count_reg, count_next;
    dq_pkg::status_t           status_reg, status_next;
    logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];
    logic [dq_pkg::DATA_W-1:0] front_rd_reg, back_rd_reg;
    logic [dq_pkg::OUT_W-1:0]  out_reg, out_next;

    logic                      wr_en;
    logic [dq_pkg::IDX_W-1:0]  wr_addr;
    logic [dq_pkg::IDX_W-1:0]  head_dec;
    logic [dq_pkg::IDX_W-1:0]  tail_slot;
    logic [dq_pkg::IDX_W-1:0]  last_slot;
    logic [dq_pkg::CNT_W-1:0]  last_off;
    logic                      is_push;
    logic                      held;

    function automatic logic [dq_pkg::IDX_W-1:0] ring_wrap(input logic [dq_pkg::CNT_W:0] s);
        logic [dq_pkg::CNT_W:0] r;
        r = (s >= dq_pkg::DEPTH_SUM) ? s - dq_pkg::DEPTH_SUM : s;
        return r[dq_pkg::IDX_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= in_data[dq_pkg::CMD_W-1:0];
            word_reg <= in_data[dq_pkg::CMD_W +: dq_pkg::DATA_W];
        end
    end

    assign head_dec  = (head_reg == '0) ? dq_pkg::LAST_IDX : head_reg - 1'b1;
    assign tail_slot = ring_wrap({1'b0, {(dq_pkg::CNT_W - dq_pkg::IDX_W){1'b0}}, head_reg}
                                 + {1'b0, count_reg});
    assign is_push   = (cmd_reg == dq_pkg::CMD_PUSH_FRONT) || (cmd_reg == dq_pkg::CMD_PUSH_BACK);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = dq_pkg::ST_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_slot;
        case (cmd_reg)
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK:
            begin
                // null data wins over full
                if (word_reg == '0)
                    status_next = dq_pkg::ST_NULL;
                else if (count_reg >= dq_pkg::DEPTH_CNT)
                    status_next = dq_pkg::ST_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (cmd_reg == dq_pkg::CMD_PUSH_FRONT)
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                end
            end
            dq_pkg::CMD_POP_FRONT:
            begin
                if (count_reg != '0)
                begin
                    head_next  = (head_reg == dq_pkg::LAST_IDX) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK:
            begin
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
            end
            dq_pkg::CMD_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
            status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute && wr_en && is_push)
            mem[wr_addr] <= word_reg;
    end

    assign held      = (count_reg != '0);
    assign last_off  = held ? count_reg - 1'b1 : '0;
    assign last_slot = ring_wrap({1'b0, {(dq_pkg::CNT_W - dq_pkg::IDX_W){1'b0}}, head_reg}
                                 + {1'b0, last_off});

    // two read ports, data registered
    always_ff @(posedge clk)
    begin
        if (ctrl.fetch)
        begin
            front_rd_reg <= mem[head_reg];
            back_rd_reg  <= mem[last_slot];
        end
    end

    always_comb
    begin
        out_next = '0;
        out_next[dq_pkg::STAT_W-1:0] = status_reg;
        out_next[dq_pkg::STAT_W +: dq_pkg::DATA_W] = held ? front_rd_reg : '0;
        out_next[dq_pkg::STAT_W + dq_pkg::DATA_W +: dq_pkg::DATA_W] =
            held ? back_rd_reg : '0;
        out_next[dq_pkg::STAT_W + 2 * dq_pkg::DATA_W] = !held;
        out_next[dq_pkg::STAT_W + 2 * dq_pkg::DATA_W + 1 +: dq_pkg::CNT_W] = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dq_pkg::DEPTH_CNT)
        else $error("fill count beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= dq_pkg::LAST_IDX)
        else $error("head index beyond depth");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute && status_next == dq_pkg::ST_FULL |=> $stable(count_reg))
        else $error("rejected push changed the count");

endmodule

// ===== design/dq_controller.sv =====
// sequencing state machine for the double-ended queue
module dq_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dq_pkg::dq_ctrl_t  ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.execute = 1'b1;
                state_next   = S_FETCH;
            end
            S_FETCH:
            begin
                ctrl.fetch = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait here while the previous result is still unclaimed
                if (out_free)
                begin
                    ctrl.load     = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("transfer in not followed by execute");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> m_tvalid)
        else $error("result loaded but not offered");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> !m_tvalid || m_tready)
        else $error("pending result overwritten");

endmodule

// ===== design/double_ended_queue.sv =====
// top level of the double-ended queue: controller and datapath
// an input transfer passes capture, update and write, two-port store read and result load in turn
//   before the result is offered on the master side; the result load waits while the master side
//   stalls the result register, and a new transfer is accepted only once the result is loaded
// a new input transfer is taken while the previous result still waits in the output register
// reset: asynchronous active-low, empties the queue (head 0, count 0); store contents not cleared
module double_ended_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [dq_pkg::IN_W-1:0]   s_tdata,  // command[2:0], data_value[34:3], zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [dq_pkg::OUT_W-1:0]  m_tdata   // status[1:0], front_value[33:2],
                                                // back_value[65:34], is_empty[66],
                                                // entry_count[71:67]
);

    dq_pkg::dq_ctrl_t ctrl;

    dq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    dq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule
